// ===== design/stl_pkg.sv =====
// Shared constants and functions for the script token lexer.
// No dependencies.
package stl_pkg;

  localparam logic [3:0] MD_IDLE   = 4'd0;
  localparam logic [3:0] MD_IDENT  = 4'd1;
  localparam logic [3:0] MD_INT    = 4'd2;
  localparam logic [3:0] MD_FRAC   = 4'd3;
  localparam logic [3:0] MD_EXPS   = 4'd4;
  localparam logic [3:0] MD_EXPD   = 4'd5;
  localparam logic [3:0] MD_STR    = 4'd6;
  localparam logic [3:0] MD_STRESC = 4'd7;
  localparam logic [3:0] MD_OP     = 4'd8;
  localparam logic [3:0] MD_LCOM   = 4'd9;
  localparam logic [3:0] MD_BCOM   = 4'd10;
  localparam logic [3:0] MD_BSTAR  = 4'd11;
  localparam logic [3:0] MD_STOP   = 4'd12;

  localparam logic [5:0] K_END   = 6'd0;
  localparam logic [5:0] K_INT   = 6'd1;
  localparam logic [5:0] K_FLOAT = 6'd2;
  localparam logic [5:0] K_STR   = 6'd3;
  localparam logic [5:0] K_NAME  = 6'd4;
  localparam logic [5:0] K_KW0   = 6'd5;
  localparam logic [5:0] K_BAD   = 6'd50;

  localparam int unsigned NumKw = 18;
  localparam int unsigned KwMaxLen = 8;
  localparam logic [62:0] V63 = {63{1'b1}};
  localparam logic [62:0] SatLimit = 63'h0CCC_CCCC_CCCC_CCCC;

  // Keywords packed little-endian with their lengths
  function automatic logic [63:0] kw_word(input logic [4:0] idx);
    logic [63:0] w;
    w = '0;
    case (idx)
      5'd0:  w = 64'h0000_6c61_626f_6c67;
      5'd1:  w = 64'h6e6f_6974_636e_7566;
      5'd2:  w = 64'h0000_0000_0000_6669;
      5'd3:  w = 64'h0000_0000_6573_6c65;
      5'd4:  w = 64'h0000_0065_6c69_6877;
      5'd5:  w = 64'h0000_6e72_7574_6572;
      5'd6:  w = 64'h0000_006b_6165_7262;
      5'd7:  w = 64'h6575_6e69_746e_6f63;
      5'd8:  w = 64'h0000_0000_6575_7274;
      5'd9:  w = 64'h0000_0065_736c_6166;
      5'd10: w = 64'h0000_0000_6c6c_756e;
      5'd11: w = 64'h0000_0000_0074_6e69;
      5'd12: w = 64'h0000_0074_616f_6c66;
      5'd13: w = 64'h0000_676e_6972_7473;
      5'd14: w = 64'h0000_0000_6c6f_6f62;
      5'd15: w = 64'h0000_0000_7473_696c;
      5'd16: w = 64'h0000_0000_0070_616d;
      5'd17: w = 64'h0000_0074_736e_6f63;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [3:0] l;
    l = '0;
    case (idx)
      5'd2: l = 4'd2;
      5'd11, 5'd16: l = 4'd3;
      5'd3, 5'd8, 5'd10, 5'd14, 5'd15: l = 4'd4;
      5'd4, 5'd6, 5'd9, 5'd12, 5'd17: l = 4'd5;
      5'd0, 5'd5, 5'd13: l = 4'd6;
      5'd1, 5'd7: l = 4'd8;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage

// ===== design/stl_kw_match.sv =====
// Keyword lookup for a finished identifier.
// Depends on stl_pkg.
module stl_kw_match import stl_pkg::*; #(
  parameter int unsigned LEN_WIDTH = 24
) (
  input  logic [63:0]          buf_i,
  input  logic [LEN_WIDTH-1:0] len_i,
  output logic [5:0]           kind_o
);
  always_comb begin
    kind_o = K_NAME;
    for (int i = NumKw - 1; i >= 0; i--) begin
      if (len_i == LEN_WIDTH'(kw_len(5'(i))) && buf_i == kw_word(5'(i))) begin
        kind_o = K_KW0 + 6'(i);
      end
    end
  end
endmodule

// ===== design/stl_out_fifo.sv =====
// Result queue: takes up to two tokens per beat, hands out one per cycle while ready_i is high.
// Depends on stl_pkg.
module stl_out_fifo import stl_pkg::*; #(
  parameter int unsigned W = 160
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   push_n_i,
  input  logic [W-1:0] push0_i,
  input  logic [W-1:0] push1_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);
  logic [W-1:0] mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic pop;
  assign pop = valid_o && ready_i;
  assign valid_o = cnt_q != 3'd0;
  assign data_o = mem_q[rd_q];
  assign room_o = cnt_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_n_i == 2'd2) mem_q[wr_q + 2'd1] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_q + push_n_i;
      rd_q <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_n_i) - 3'(pop);
    end
  end
endmodule

// ===== design/script_token_lexer.sv =====
// Streaming lexer top level: one source byte per beat, token beats out.
// Depends on stl_pkg, stl_kw_match, stl_out_fifo.
// Takes one byte every cycle while the four-entry result queue has room for
// two more tokens; a byte yields up to two tokens, drained one per cycle while
// ready_i is high, so token-dense text runs at one byte per cycle except when
// two-token bytes come back to back or ready_i is low: the output sets the pace.
module script_token_lexer import stl_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = 24,
  parameter int unsigned LINE_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  source_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [5:0]  token_kind_o,
  output logic [23:0] start_offset_o,
  output logic [23:0] text_length_o,
  output logic [23:0] token_line_o,
  output logic [62:0] integer_value_o,
  output logic        last_of_run_o
);
  typedef struct packed {
    logic [5:0] kind; logic [23:0] off; logic [23:0] len;
    logic [23:0] ln; logic [62:0] val; logic last;
  } tok_t;
  localparam int unsigned TW = $bits(tok_t);
  localparam logic [OFFSET_WIDTH-1:0] OffMax = '1;
  localparam logic [LINE_WIDTH-1:0] LineMax = '1;

  logic [3:0] mode_q, mode_d;
  logic [7:0] pend_q, pend_d;
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d, tstart_q, tstart_d, tlen_q, tlen_d;
  logic [LINE_WIDTH-1:0] line_q, line_d, sline_q, sline_d;
  logic [62:0] acc_q, acc_d;
  logic [63:0] kbuf_q, kbuf_d;
  logic [5:0] kw_kind;
  logic room, acc_in;
  logic [1:0] n;
  tok_t t0, t1, tw;
  logic [7:0] c;

  stl_kw_match #(.LEN_WIDTH(OFFSET_WIDTH)) u_kw (
    .buf_i(kbuf_q), .len_i(tlen_q), .kind_o(kw_kind)
  );

  assign ready_o = room;
  assign acc_in = valid_i && ready_o;
  assign c = source_byte_i;

  function automatic tok_t mk(input logic [5:0] k, input logic [OFFSET_WIDTH-1:0] o,
                              input logic [OFFSET_WIDTH-1:0] l,
                              input logic [LINE_WIDTH-1:0] ln, input logic [62:0] v);
    tok_t t;
    t.kind = k;
    t.off = 24'(o);
    t.len = 24'(l);
    t.ln = 24'(ln);
    t.val = v;
    t.last = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [OFFSET_WIDTH-1:0] tl1;
    logic [LINE_WIDTH-1:0] li1;
    logic [5:0] ok;
    logic dispatch, used;
    logic [62:0] a10;
    logic [3:0] dgt;
    mode_d = mode_q; pend_d = pend_q; pos_d = pos_q; tstart_d = tstart_q;
    tlen_d = tlen_q; line_d = line_q; sline_d = sline_q; acc_d = acc_q; kbuf_d = kbuf_q;
    n = 2'd0; t0 = '0; t1 = '0; tw = '0;
    tl1 = (tlen_q < OffMax) ? tlen_q + 1'b1 : tlen_q;
    li1 = (line_q < LineMax) ? line_q + 1'b1 : line_q;
    dispatch = 1'b0; used = 1'b0; ok = K_END;
    dgt = c[3:0];
    a10 = (acc_q << 3) + (acc_q << 1) + 63'(dgt);
    case (pend_q)
      8'h2d: ok = 6'd24;
      8'h2f: ok = 6'd27;
      8'h3d: ok = 6'd39;
      8'h21: ok = 6'd41;
      8'h3c: ok = 6'd43;
      8'h3e: ok = 6'd45;
      default: ok = K_BAD;
    endcase
    if (c == 8'h00) begin
      case (mode_q)
        MD_IDENT: begin t0 = mk(kw_kind, tstart_q, tlen_q, sline_q, '0); n = 2'd1; end
        MD_INT: begin t0 = mk(K_INT, tstart_q, tlen_q, sline_q, acc_q); n = 2'd1; end
        MD_FRAC, MD_EXPS, MD_EXPD: begin
          t0 = mk(K_FLOAT, tstart_q, tlen_q, sline_q, '0); n = 2'd1;
        end
        MD_STR, MD_STRESC: begin t0 = mk(K_STR, tstart_q, tlen_q, sline_q, '0); n = 2'd1; end
        MD_OP: begin t0 = mk(ok, tstart_q, OFFSET_WIDTH'(1), sline_q, '0); n = 2'd1; end
        default: ;
      endcase
      if (n == 2'd1) t1 = mk(K_END, pos_q, '0, line_q, '0);
      else t0 = mk(K_END, pos_q, '0, line_q, '0);
      n = n + 2'd1;
      mode_d = MD_IDLE; pend_d = '0; pos_d = '0; tstart_d = '0; tlen_d = '0;
      line_d = LINE_WIDTH'(1); sline_d = LINE_WIDTH'(1); acc_d = '0; kbuf_d = '0;
    end else begin
      pos_d = pos_q + 1'b1;
      case (mode_q)
        MD_STOP: ;
        MD_IDENT: begin
          if (is_alpha(c) || is_dig(c) || c == 8'h5f) begin
            if (tlen_q < KwMaxLen) kbuf_d = kbuf_q | (64'(c) << {tlen_q[2:0], 3'b000});
            tlen_d = tl1;
          end else begin
            t0 = mk(kw_kind, tstart_q, tlen_q, sline_q, '0); n = 2'd1;
            mode_d = MD_IDLE; dispatch = 1'b1;
          end
        end
        MD_INT: begin
          if (is_dig(c)) begin
            if (acc_q > SatLimit || (acc_q == SatLimit && dgt > 4'd7)) acc_d = V63;
            else acc_d = a10;
            tlen_d = tl1;
          end else if (c == 8'h2e) begin mode_d = MD_FRAC; tlen_d = tl1; end
          else if (c == 8'h65 || c == 8'h45) begin mode_d = MD_EXPS; tlen_d = tl1; end
          else begin
            t0 = mk(K_INT, tstart_q, tlen_q, sline_q, acc_q); n = 2'd1;
            mode_d = MD_IDLE; dispatch = 1'b1;
          end
        end
        MD_FRAC, MD_EXPS, MD_EXPD: begin
          if (mode_q == MD_EXPS && (is_dig(c) || c == 8'h2b || c == 8'h2d)) begin
            mode_d = MD_EXPD; tlen_d = tl1;
          end else if (mode_q != MD_EXPS && is_dig(c)) tlen_d = tl1;
          else if (mode_q == MD_FRAC && (c == 8'h65 || c == 8'h45)) begin
            mode_d = MD_EXPS; tlen_d = tl1;
          end else begin
            t0 = mk(K_FLOAT, tstart_q, tlen_q, sline_q, '0); n = 2'd1;
            mode_d = MD_IDLE; dispatch = 1'b1;
          end
        end
        MD_STR: begin
          if (c == 8'h22) begin
            t0 = mk(K_STR, tstart_q, tlen_q, sline_q, '0); n = 2'd1; mode_d = MD_IDLE;
          end else begin
            if (c == 8'h5c) mode_d = MD_STRESC;
            else if (c == 8'h0a) line_d = li1;
            tlen_d = tl1;
          end
        end
        MD_STRESC: begin
          if (c == 8'h0a) line_d = li1;
          tlen_d = tl1; mode_d = MD_STR;
        end
        MD_OP: begin
          used = 1'b1; mode_d = MD_IDLE; ok = 6'd0;
          if (pend_q == 8'h2f && c == 8'h2f) mode_d = MD_LCOM;
          else if (pend_q == 8'h2f && c == 8'h2a) mode_d = MD_BCOM;
          else if (pend_q == 8'h2d && c == 8'h3e) ok = 6'd25;
          else if (pend_q == 8'h2e && c == 8'h2e) ok = 6'd38;
          else if (pend_q == 8'h3d && c == 8'h3d) ok = 6'd40;
          else if (pend_q == 8'h21 && c == 8'h3d) ok = 6'd42;
          else if (pend_q == 8'h3c && c == 8'h3d) ok = 6'd44;
          else if (pend_q == 8'h3e && c == 8'h3d) ok = 6'd46;
          else if (pend_q == 8'h26 && c == 8'h26) ok = 6'd48;
          else if (pend_q == 8'h7c && c == 8'h7c) ok = 6'd49;
          else used = 1'b0;
          if (ok != 6'd0) begin
            t0 = mk(ok, tstart_q, OFFSET_WIDTH'(2), sline_q, '0); n = 2'd1;
          end
          if (!used) begin
            case (pend_q)
              8'h2d: ok = 6'd24;
              8'h2f: ok = 6'd27;
              8'h3d: ok = 6'd39;
              8'h21: ok = 6'd41;
              8'h3c: ok = 6'd43;
              8'h3e: ok = 6'd45;
              default: ok = K_BAD;
            endcase
            t0 = mk(ok, tstart_q, OFFSET_WIDTH'(1), sline_q, '0); n = 2'd1;
            if (ok == K_BAD) mode_d = MD_STOP;
            else dispatch = 1'b1;
          end
        end
        MD_LCOM: if (c == 8'h0a) begin line_d = li1; mode_d = MD_IDLE; end
        MD_BCOM, MD_BSTAR: begin
          if (mode_q == MD_BSTAR && c == 8'h2f) mode_d = MD_IDLE;
          else if (c == 8'h2a) mode_d = MD_BSTAR;
          else begin
            if (c == 8'h0a) line_d = li1;
            mode_d = MD_BCOM;
          end
        end
        default: begin mode_d = MD_IDLE; dispatch = 1'b1; end
      endcase
      if (dispatch) begin
        ok = 6'd0;
        if (c == 8'h0a) line_d = li1;
        else if (c == 8'h20 || c == 8'h09 || c == 8'h0d) ;
        else if (is_dig(c)) begin
          mode_d = MD_INT; tstart_d = pos_q; sline_d = line_q; tlen_d = OFFSET_WIDTH'(1);
          acc_d = 63'(dgt);
        end else if (is_alpha(c) || c == 8'h5f) begin
          mode_d = MD_IDENT; tstart_d = pos_q; sline_d = line_q; tlen_d = OFFSET_WIDTH'(1);
          kbuf_d = 64'(c);
        end else if (c == 8'h22) begin
          mode_d = MD_STR; tstart_d = pos_q + 1'b1; sline_d = line_q; tlen_d = '0;
        end else begin
          case (c)
            8'h2b: ok = 6'd23;
            8'h2a: ok = 6'd26;
            8'h25: ok = 6'd28;
            8'h28: ok = 6'd29;
            8'h29: ok = 6'd30;
            8'h7b: ok = 6'd31;
            8'h7d: ok = 6'd32;
            8'h5b: ok = 6'd33;
            8'h5d: ok = 6'd34;
            8'h2c: ok = 6'd35;
            8'h3b: ok = 6'd36;
            8'h23: ok = 6'd37;
            8'h3a: ok = 6'd47;
            8'h2d, 8'h2e, 8'h3d, 8'h21, 8'h3c, 8'h3e, 8'h26, 8'h7c, 8'h2f: begin
              mode_d = MD_OP; tstart_d = pos_q; sline_d = line_q;
              tlen_d = OFFSET_WIDTH'(1); pend_d = c;
            end
            default: begin ok = K_BAD; mode_d = MD_STOP; end
          endcase
          if (ok != 6'd0) begin
            tw = mk(ok, pos_q, OFFSET_WIDTH'(1), line_q, '0);
            if (n == 2'd0) t0 = tw; else t1 = tw;
            n = n + 2'd1;
          end
        end
      end
    end
    if (n == 2'd1) t0.last = 1'b1;
    if (n == 2'd2) t1.last = 1'b1;
    if (!acc_in) n = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MD_IDLE; pend_q <= '0; pos_q <= '0; tstart_q <= '0; tlen_q <= '0;
      line_q <= LINE_WIDTH'(1); sline_q <= LINE_WIDTH'(1); acc_q <= '0; kbuf_q <= '0;
    end else if (acc_in) begin
      mode_q <= mode_d; pend_q <= pend_d; pos_q <= pos_d; tstart_q <= tstart_d;
      tlen_q <= tlen_d; line_q <= line_d; sline_q <= sline_d; acc_q <= acc_d;
      kbuf_q <= kbuf_d;
    end
  end

  tok_t to;
  stl_out_fifo #(.W(TW)) u_fifo (
    .clk_i, .rst_ni, .push_n_i(n), .push0_i(t0), .push1_i(t1), .room_o(room),
    .valid_o, .ready_i, .data_o(to)
  );
  assign token_kind_o = to.kind;
  assign start_offset_o = to.off;
  assign text_length_o = to.len;
  assign token_line_o = to.ln;
  assign integer_value_o = to.val;
  assign last_of_run_o = to.last;

  a_zero_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && c == 8'h00) |=> (mode_q == MD_IDLE && pos_q == '0))
    else $error("zero byte did not reset scanner");
  a_line_min: assert property (@(posedge clk_i) disable iff (!rst_ni) line_q != '0)
    else $error("line count zero");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni) acc_in |-> room)
    else $error("byte accepted without queue room");
endmodule
